FILE: rtl/core/sa_pkg.sv
// Shared types and constants for the slot allocator.
// No dependencies; imported by every module of the block except sa_ram.
package sa_pkg;

   localparam int SLOT_W     = 10;
   localparam int TIME_W     = 32;
   localparam int RES_W      = 11;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_SLOTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE          = 2'd2;

   localparam logic [RES_W-1:0]  RESERVED_RESET = 11'd1;
   localparam logic [TIME_W-1:0] STARTUP_RESET  = 32'd2000;
   localparam logic [TIME_W-1:0] GRACE_RESET    = 32'd500;

   typedef struct packed {
      logic [RES_W-1:0]  reserved_slots;
      logic [TIME_W-1:0] startup_window_ms;
      logic [TIME_W-1:0] grace_ms;
   } cfg_type;

endpackage

FILE: rtl/core/sa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sa_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sa_csr.sv
// Configuration registers of the slot allocator, written over the csr channel.
// Depends on sa_pkg.
module sa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output sa_pkg::cfg_type                  cfg
);
   import sa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RESERVED_SLOTS: cfg_in.reserved_slots    = csr_wdata[RES_W-1:0];
            CSR_STARTUP_WINDOW: cfg_in.startup_window_ms = csr_wdata[TIME_W-1:0];
            CSR_GRACE:          cfg_in.grace_ms          = csr_wdata[TIME_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reserved_slots    <= RESERVED_RESET;
         cfg_ff.startup_window_ms <= STARTUP_RESET;
         cfg_ff.grace_ms          <= GRACE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

FILE: rtl/core/slot_allocator_with_reuse_delay.sv
// Slot allocator with reuse delay: first-fit scan over a slot table held in RAM.
// Depends on sa_pkg, sa_ram and sa_csr.
//
// Usage:
//   A transaction is taken when start is high and busy is low. req_command
//   selects allocate or free; req_slot_index names the slot to free and
//   req_now_ms carries the current time.
//   Each transaction yields one result: rsp_valid is high for one cycle with
//   rsp_given_slot and rsp_status. The receiver cannot stall.
//   Free, and allocate with no slot to scan: result on the next cycle.
//   Allocate with a scan: the table entries from reserved_slots upward are
//   examined in order (at most high-water minus reserved_slots of them); the
//   table RAM delivers one entry per cycle, and the result is registered after the last.
//   busy is high while the scan runs, so the next transaction can be taken
//   straight after a free and only once the scan of an allocate has ended.
//   Configuration is written on the csr channel (always ready) while idle.
//   Reset (synchronous) empties the table by clearing the high-water count
//   and loads the register defaults; the RAM contents are not cleared.
module slot_allocator_with_reuse_delay #(
   parameter int SLOTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [sa_pkg::SLOT_W-1:0]     req_slot_index,
   input  logic [sa_pkg::TIME_W-1:0]     req_now_ms,
   output logic                          rsp_valid,
   output logic [sa_pkg::SLOT_W-1:0]     rsp_given_slot,
   output logic [sa_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sa_pkg::*;

   localparam int AW   = $clog2(SLOTS);
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int CMPW = (CW > RES_W) ? CW : RES_W;
   localparam int MEMW = TIME_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       hw_ff, hw_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   given_ff, given_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   cfg_type             cfg;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [MEMW-1:0]     wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [MEMW-1:0]     rd_data;

   logic [CMPW-1:0]     hw_ext, res_ext, slot_ext, ptr_ext;
   logic [CMPW-1:0]     at_ext, at_next;
   logic                at_full;
   logic                hit_flag;
   logic [TIME_W-1:0]   hit_stamp;
   logic [TIME_W-1:0]   age;
   logic                reusable;
   logic [CW-1:0]       ptr_next;
   logic                last;
   logic                hw_full;
   logic [CW-1:0]       hw_next;

   sa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // entry layout: {free flag, free stamp}
   sa_ram #(
      .WIDTH (MEMW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hw_ext   = CMPW'(hw_ff);
   assign res_ext  = CMPW'(cfg.reserved_slots);
   assign slot_ext = CMPW'(req_slot_index);
   assign ptr_ext  = CMPW'(ptr_ff);
   assign at_ext   = (hw_ext > res_ext) ? hw_ext : res_ext;
   assign at_full  = at_ext >= CMPW'(SLOTS);
   assign at_next  = at_ext + CMPW'(1);

   assign hit_flag  = rd_data[MEMW-1];
   assign hit_stamp = rd_data[TIME_W-1:0];
   assign age       = now_ff - hit_stamp;
   assign reusable  = hit_flag &&
                      ((hit_stamp < cfg.startup_window_ms) ||
                       ((now_ff >= hit_stamp) && (age > cfg.grace_ms)));

   assign ptr_next = ptr_ff + CW'(1);
   assign last     = ptr_next == hw_ff;
   assign hw_full  = hw_ff == CW'(SLOTS);
   assign hw_next  = hw_ff + CW'(1);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      hw_in        = hw_ff;
      now_in       = now_ff;
      rsp_valid_in = 1'b0;
      given_in     = given_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               now_in    = req_now_ms;
               given_in  = '0;
               status_in = STATUS_OK;
               if (req_command == CMD_FREE) begin
                  rsp_valid_in = 1'b1;
                  if (slot_ext >= hw_ext) begin
                     status_in = STATUS_INVALID;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = slot_ext[AW-1:0];
                     wr_data = {1'b1, req_now_ms};
                  end
               end else if (res_ext < hw_ext) begin
                  rd_en    = 1'b1;
                  rd_addr  = res_ext[AW-1:0];
                  ptr_in   = res_ext[CW-1:0];
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (at_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = at_ext[AW-1:0];
                     wr_data  = {1'b0, req_now_ms};
                     hw_in    = at_next[CW-1:0];
                     given_in = at_ext[SLOT_W-1:0];
                  end
               end
            end
         end
         ST_SCAN: begin
            if (reusable) begin
               wr_en        = 1'b1;
               wr_addr      = ptr_ff[AW-1:0];
               wr_data      = {1'b0, hit_stamp};
               given_in     = ptr_ext[SLOT_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (hw_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = hw_ff[AW-1:0];
                  wr_data  = {1'b0, now_ff};
                  hw_in    = hw_next;
                  given_in = hw_ext[SLOT_W-1:0];
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_next[AW-1:0];
               ptr_in  = ptr_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      now_ff    <= now_in;
      given_ff  <= given_in;
      status_ff <= status_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_given_slot = given_ff;
   assign rsp_status     = status_ff;

endmodule

FILE: tb/sv/tb_slot_allocator_with_reuse_delay.sv
// Self-checking testbench for slot_allocator_with_reuse_delay: directed and random
// allocate/free transactions are checked against an in-bench table predictor.
// Depends on sa_pkg and the slot_allocator_with_reuse_delay RTL.
module tb_slot_allocator_with_reuse_delay;
   timeunit 1ns;
   timeprecision 1ps;

   import sa_pkg::*;

   localparam int          SLOTS     = 1024;
   localparam int unsigned RUN_LIMIT = 4000000;

   typedef struct packed {
      logic              cmd;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] now;
   } slot_cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   given;
      logic [STATUS_W-1:0] status;
   } slot_grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_command = CMD_ALLOC;
   logic [SLOT_W-1:0]     req_slot_index = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic [SLOT_W-1:0]     rsp_given_slot;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_RESERVED_SLOTS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   bit                slot_free    [SLOTS] = '{default: 1'b0};
   logic [TIME_W-1:0] slot_stamp   [SLOTS] = '{default: '0};
   bit                slot_written [SLOTS] = '{default: 1'b0};
   int unsigned       hw_count = 0;
   logic [RES_W-1:0]  cfg_reserved = RESERVED_RESET;
   logic [TIME_W-1:0] cfg_startup  = STARTUP_RESET;
   logic [TIME_W-1:0] cfg_grace    = GRACE_RESET;

   slot_cmd_type   cmd_queue[$];
   slot_grant_type pending_grants[$];
   slot_cmd_type   cur_cmd;
   int          gap_pct = 21;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   logic [TIME_W-1:0] sim_ms = '0;

   slot_allocator_with_reuse_delay #(.SLOTS(SLOTS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_slot_index(req_slot_index),
      .req_now_ms(req_now_ms), .rsp_valid(rsp_valid),
      .rsp_given_slot(rsp_given_slot), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic slot_grant_type predict_grant(slot_cmd_type c);
      slot_grant_type g;
      int unsigned idx;
      int unsigned at;
      bit hit;
      g.given  = '0;
      g.status = STATUS_OK;
      hit      = 1'b0;
      if (c.cmd == CMD_FREE) begin
         if (c.slot >= hw_count) begin
            g.status = STATUS_INVALID;
         end else begin
            slot_free[c.slot]    = 1'b1;
            slot_stamp[c.slot]   = c.now;
            slot_written[c.slot] = 1'b1;
         end
      end else begin
         for (idx = cfg_reserved; idx < hw_count && !hit; idx++) begin
            if (slot_free[idx] && (slot_stamp[idx] < cfg_startup ||
                (c.now >= slot_stamp[idx] && c.now - slot_stamp[idx] > cfg_grace))) begin
               slot_free[idx] = 1'b0;
               g.given = idx[SLOT_W-1:0];
               hit = 1'b1;
            end
         end
         if (!hit) begin
            at = (hw_count > cfg_reserved) ? hw_count : cfg_reserved;
            if (at >= SLOTS) begin
               g.status = STATUS_FULL;
            end else begin
               slot_free[at]    = 1'b0;
               slot_written[at] = 1'b1;
               hw_count = at + 1;
               g.given  = at[SLOT_W-1:0];
            end
         end
      end
      return g;
   endfunction

   // lowest reserved_slots value whose scan touches only written entries
   function automatic int unsigned min_safe_reserved();
      int unsigned r;
      r = hw_count;
      while (r > 0 && slot_written[r-1]) r--;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pending_grants.push_back(predict_grant(cur_cmd));
         end
         if (!start || !busy) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
               cur_cmd = cmd_queue.pop_front();
               start          <= 1'b1;
               req_command    <= cur_cmd.cmd;
               req_slot_index <= cur_cmd.slot;
               req_now_ms     <= cur_cmd.now;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      slot_grant_type exp_grant;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_grants.size() == 0) begin
            $display("%0t unexpected result given_slot %0d status %0d",
                     $time, rsp_given_slot, rsp_status);
            mismatch_count++;
         end else begin
            exp_grant = pending_grants.pop_front();
            if (rsp_given_slot !== exp_grant.given) begin
               $display("%0t given_slot expected %0d actual %0d",
                        $time, exp_grant.given, rsp_given_slot);
               mismatch_count++;
            end
            if (rsp_status !== exp_grant.status) begin
               $display("%0t status expected %0d actual %0d",
                        $time, exp_grant.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_cmd(logic cmd, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] now);
      slot_cmd_type c;
      c.cmd  = cmd;
      c.slot = slot;
      c.now  = now;
      sim_ms = now;
      cmd_queue.push_back(c);
      while (cmd_queue.size() > 1) @(posedge clock);
   endtask

   task automatic settle();
      while (cmd_queue.size() != 0 || start || busy || pending_grants.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_RESERVED_SLOTS: cfg_reserved = data[RES_W-1:0];
         CSR_STARTUP_WINDOW: cfg_startup  = data;
         CSR_GRACE:          cfg_grace    = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_reserved(int unsigned wanted);
      int unsigned floor_r;
      floor_r = min_safe_reserved();
      write_csr(CSR_RESERVED_SLOTS, (wanted > floor_r) ? wanted : floor_r);
   endtask

   task automatic random_cmds(int count, int free_pct, int bad_pct);
      int r;
      int fp;
      logic cmd;
      logic [SLOT_W-1:0] slot;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 3 && sim_ms > 600) sim_ms -= $urandom_range(1, 600);
         else if (r < 50) sim_ms += $urandom_range(0, 20);
         else if (r < 85) sim_ms += $urandom_range(0, 400);
         else sim_ms += $urandom_range(300, 2000);
         fp = (hw_count > 200) ? 70 : free_pct;
         cmd = ($urandom_range(0, 99) < fp) ? CMD_FREE : CMD_ALLOC;
         if (hw_count == 0 || $urandom_range(0, 99) < bad_pct)
            slot = SLOT_W'($urandom_range(0, SLOTS - 1));
         else
            slot = SLOT_W'($urandom_range(0, hw_count - 1));
         push_cmd(cmd, slot, sim_ms);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reserved 0 before any append so slot 0 never gets skipped
      gap_pct = 21;
      write_csr(CSR_RESERVED_SLOTS, 0);
      push_cmd(CMD_FREE,  10'd5,    32'd0);
      push_cmd(CMD_ALLOC, 10'd0,    32'd0);
      push_cmd(CMD_ALLOC, 10'd0,    32'd10);
      push_cmd(CMD_ALLOC, 10'd1023, 32'd10);
      push_cmd(CMD_ALLOC, 10'd0,    32'd20);
      push_cmd(CMD_FREE,  10'd1,    32'd100);
      push_cmd(CMD_ALLOC, 10'd0,    32'd100);
      push_cmd(CMD_FREE,  10'd0,    32'd100);
      push_cmd(CMD_FREE,  10'd0,    32'd150);
      push_cmd(CMD_FREE,  10'd3,    32'd150);
      push_cmd(CMD_FREE,  10'd1023, 32'd150);
      push_cmd(CMD_FREE,  10'd4,    32'd150);
      push_cmd(CMD_FREE,  10'd2,    32'd3000);
      push_cmd(CMD_ALLOC, 10'd0,    32'd3300);
      push_cmd(CMD_ALLOC, 10'd0,    32'd3400);
      push_cmd(CMD_ALLOC, 10'd0,    32'd3400);
      push_cmd(CMD_ALLOC, 10'd0,    32'd3500);
      push_cmd(CMD_ALLOC, 10'd0,    32'd3501);
      push_cmd(CMD_FREE,  10'd1,    32'd5000);
      push_cmd(CMD_ALLOC, 10'd0,    32'd4000);
      push_cmd(CMD_FREE,  10'd4,    32'hFFFF_FFF0);
      push_cmd(CMD_ALLOC, 10'd0,    32'hFFFF_FFFF);
      push_cmd(CMD_ALLOC, 10'd0,    32'd0);
      settle();

      sim_ms = 32'd10000;
      random_cmds(270, 45, 10);
      settle();

      gap_pct = 78;
      write_csr(CSR_STARTUP_WINDOW, 0);
      write_csr(CSR_GRACE, 0);
      set_reserved(min_safe_reserved() + $urandom_range(0, 4));
      random_cmds(270, 45, 10);
      settle();

      gap_pct = 0;
      write_csr(CSR_GRACE, 32'hFFFF_FFFF);
      set_reserved(0);
      random_cmds(130, 55, 10);
      settle();

      write_csr(CSR_STARTUP_WINDOW, 32'hFFFF_FFFF);
      write_csr(CSR_GRACE, $urandom_range(50, 800));
      sim_ms = 32'hFFF0_0000;
      random_cmds(65, 45, 10);
      settle();
      write_csr(CSR_STARTUP_WINDOW, $urandom_range(1000, 32'hFFF8_0000));
      random_cmds(65, 45, 10);
      settle();

      // fill the top of the table until it reports full
      write_csr(CSR_STARTUP_WINDOW, STARTUP_RESET);
      write_csr(CSR_GRACE, GRACE_RESET);
      set_reserved(1000);
      sim_ms = 32'd50000;
      random_cmds(45, 15, 10);
      settle();

      write_csr(CSR_RESERVED_SLOTS, SLOTS);
      push_cmd(CMD_ALLOC, 10'd0,    sim_ms + 10);
      push_cmd(CMD_FREE,  10'd1023, sim_ms + 10);
      push_cmd(CMD_FREE,  10'd1010, sim_ms + 10);
      push_cmd(CMD_ALLOC, 10'd0,    sim_ms + 5000);
      push_cmd(CMD_ALLOC, 10'd0,    sim_ms + 10);
      settle();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_grants.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/sa_pkg.sv
rtl/core/sa_ram.sv
rtl/core/sa_csr.sv
rtl/core/slot_allocator_with_reuse_delay.sv
tb/sv/tb_slot_allocator_with_reuse_delay.sv
